// ===== rtl/layered_dag_shortest_path_top_macros.svh =====
// Assertion macros shared by the layered DAG shortest path RTL.
`ifndef LAYERED_DAG_SHORTEST_PATH_TOP_MACROS_SVH
`define LAYERED_DAG_SHORTEST_PATH_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define LDSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define LDSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ldsp_pkg.sv =====
// Types and constants of the layered DAG shortest path block.
`timescale 1ns / 1ps
package ldsp_pkg;

  localparam int unsigned NODE_W   = 10;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned COST_W   = 32;
  localparam int unsigned LAYER_W  = 6;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COST_W-1:0] COST_UNREACHED = '1;

  localparam logic KIND_RELAX = 1'b0;
  localparam logic KIND_SOLVE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_UNREACH  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NO_GRAPH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_LAYER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [NODE_W-1:0]   src_node;
    logic [NODE_W-1:0]   dst_node;
    logic [WEIGHT_W-1:0] weight;
  } ldsp_in_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [NODE_W-1:0]  node;
    logic [COST_W-1:0]  goal_cost;
    logic [STAT_W-1:0]  status;
    logic               last;
  } ldsp_out_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] parent;
    logic [COST_W-1:0] cost;
  } ldsp_entry_t;

  typedef struct packed {
    logic              improve;
    logic [COST_W-1:0] cost;
  } ldsp_relax_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RELAX,
    ST_SOLVE,
    ST_SCAN,
    ST_GOAL,
    ST_STEP
  } ldsp_state_e;

endpackage

// ===== rtl/layered_dag_shortest_path_top.sv =====
// Top level of the layered DAG shortest path block: node store and solve sequencer.
`timescale 1ns / 1ps
//  channel  direction  signals                          request
//  in       input      in_valid_i/in_ready_o/in_data_i  relax edge or solve
//  out      output     out_valid_o/out_ready_i/out_data_o  one path node
//  cfg      input      cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i  register write
//
//  Relax: one read of both end nodes, then a write-back of the node store.
//  Solve: a scan of the nodes from last_layer_start up to node_count, then the goal result,
//  then one parent step per layer, one store read each; a held output register stalls it.
//  After reset and after every solve a clearing sweep of all MAX_NODES entries runs; no
//  request is taken during it, config writes are. A solve stalls while out is full.
`include "layered_dag_shortest_path_top_macros.svh"
module layered_dag_shortest_path_top #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned MAX_LAYERS  = 63,
  parameter int unsigned WEIGHT_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ldsp_pkg::ldsp_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ldsp_pkg::ldsp_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ldsp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ldsp_pkg::CNT_W-1:0]     cfg_data_i
);
  import ldsp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam logic [CNT_W-1:0] NCAP = (MAX_NODES > 2047) ? {CNT_W{1'b1}} : CNT_W'(MAX_NODES);
  localparam logic [LAYER_W-1:0] LCAP = LAYER_W'(MAX_LAYERS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

  ldsp_state_e state_q, state_d;

  logic [CNT_W-1:0]   node_count_q;
  logic [NODE_W-1:0]  lls_q;
  logic [LAYER_W-1:0] layer_count_q;

  logic [NODE_W-1:0]   src_q, src_d;
  logic [NODE_W-1:0]   dst_q, dst_d;
  logic [WEIGHT_W-1:0] weight_q, weight_d;
  logic                ign_q, ign_d;

  logic [CNT_W-1:0]   scan_idx_q, scan_idx_d;
  logic [NODE_W-1:0]  scan_addr_q, scan_addr_d;
  logic [NODE_W-1:0]  goal_q, goal_d;
  logic [COST_W-1:0]  best_cost_q, best_cost_d;
  ldsp_entry_t        best_word_q, best_word_d;
  logic [LAYER_W-1:0] step_layer_q, step_layer_d;
  logic               from_mem_q, from_mem_d;
  logic [AW-1:0]      clr_idx_q, clr_idx_d;

  logic      out_valid_q, out_valid_d;
  ldsp_out_t out_q, out_d;
  logic      out_load;

  ldsp_entry_t mem_q [MAX_NODES];
  ldsp_entry_t rd_a_q, rd_b_q;
  logic        mem_re, mem_we;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  ldsp_entry_t wdata;

  logic [CNT_W-1:0]   n_live;
  logic [LAYER_W-1:0] l_eff;
  logic               in_fire, slot_free, scan_more;
  logic [LAYER_W-1:0] t_next;
  ldsp_entry_t        cur;
  ldsp_relax_t        relax;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign n_live    = (node_count_q > NCAP) ? NCAP : node_count_q;
  assign l_eff     = (layer_count_q > LCAP) ? LCAP : layer_count_q;
  assign scan_more = scan_idx_q < n_live;
  assign t_next    = step_layer_q - LAYER_W'(1);
  assign cur       = from_mem_q ? rd_a_q : best_word_q;

  ldsp_relax_unit #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_relax (
    .cost_src_i(rd_a_q.cost),
    .cost_dst_i(rd_b_q.cost),
    .weight_i  (weight_q),
    .ignore_i  (ign_q),
    .relax_o   (relax)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_idx_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) state_d = (in_data_i.kind == KIND_SOLVE) ? ST_SOLVE : ST_RELAX;
      end
      ST_RELAX: state_d = ST_IDLE;
      ST_SOLVE: begin
        if (n_live == '0 || {1'b0, lls_q} >= n_live) begin
          if (slot_free) state_d = ST_CLEAR;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: if (!scan_more) state_d = ST_GOAL;
      ST_GOAL: begin
        if (slot_free) begin
          if (best_cost_q == COST_UNREACHED || l_eff == '0) state_d = ST_CLEAR;
          else state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (slot_free && (!cur.valid || t_next == '0)) state_d = ST_CLEAR;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    raddr_a      = AW'(in_data_i.src_node);
    raddr_b      = AW'(in_data_i.dst_node);
    waddr        = AW'(dst_q);
    wdata        = '{valid: 1'b1, parent: src_q, cost: relax.cost};
    src_d        = src_q;
    dst_d        = dst_q;
    weight_d     = weight_q;
    ign_d        = ign_q;
    scan_idx_d   = scan_idx_q;
    scan_addr_d  = scan_addr_q;
    goal_d       = goal_q;
    best_cost_d  = best_cost_q;
    best_word_d  = best_word_q;
    step_layer_d = step_layer_q;
    from_mem_d   = from_mem_q;
    clr_idx_d    = clr_idx_q;
    out_load     = 1'b0;
    out_d        = out_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        waddr     = clr_idx_q;
        wdata     = '{valid: 1'b0, parent: '0,
                      cost: (clr_idx_q == '0) ? '0 : COST_UNREACHED};
        clr_idx_d = (clr_idx_q == LAST_ADDR) ? '0 : clr_idx_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_fire && in_data_i.kind == KIND_RELAX) begin
          mem_re   = 1'b1;
          src_d    = in_data_i.src_node;
          dst_d    = in_data_i.dst_node;
          weight_d = in_data_i.weight;
          ign_d    = ({1'b0, in_data_i.src_node} >= n_live) ||
                     ({1'b0, in_data_i.dst_node} >= n_live);
        end
      end
      ST_RELAX: mem_we = relax.improve;
      ST_SOLVE: begin
        if (n_live == '0) begin
          out_load = slot_free;
          out_d    = '{layer: '0, node: '0, goal_cost: '0,
                       status: STATUS_NO_GRAPH, last: 1'b1};
        end else if ({1'b0, lls_q} >= n_live) begin
          out_load = slot_free;
          out_d    = '{layer: l_eff, node: '0, goal_cost: COST_UNREACHED,
                       status: STATUS_UNREACH, last: 1'b1};
        end else begin
          mem_re      = 1'b1;
          raddr_a     = AW'(lls_q);
          scan_addr_d = lls_q;
          scan_idx_d  = {1'b0, lls_q} + CNT_W'(1);
          best_cost_d = COST_UNREACHED;
          goal_d      = lls_q;
        end
      end
      ST_SCAN: begin
        if (rd_a_q.cost < best_cost_q) begin
          best_cost_d = rd_a_q.cost;
          best_word_d = rd_a_q;
          goal_d      = scan_addr_q;
        end
        if (scan_more) begin
          mem_re      = 1'b1;
          raddr_a     = AW'(scan_idx_q);
          scan_addr_d = scan_idx_q[NODE_W-1:0];
          scan_idx_d  = scan_idx_q + CNT_W'(1);
        end
      end
      ST_GOAL: begin
        out_load = slot_free;
        if (best_cost_q == COST_UNREACHED) begin
          out_d = '{layer: l_eff, node: goal_q, goal_cost: COST_UNREACHED,
                    status: STATUS_UNREACH, last: 1'b1};
        end else begin
          out_d = '{layer: l_eff, node: goal_q, goal_cost: best_cost_q,
                    status: STATUS_OK, last: (l_eff == '0)};
        end
        step_layer_d = l_eff;
        from_mem_d   = 1'b0;
      end
      ST_STEP: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (!cur.valid) begin
            out_d = '{layer: t_next, node: '0, goal_cost: best_cost_q,
                      status: STATUS_UNREACH, last: 1'b1};
          end else begin
            out_d = '{layer: t_next, node: cur.parent, goal_cost: best_cost_q,
                      status: STATUS_OK, last: (t_next == '0)};
            if (t_next != '0) begin
              mem_re       = 1'b1;
              raddr_a      = AW'(cur.parent);
              step_layer_d = t_next;
              from_mem_d   = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_idx_q     <= '0;
      out_valid_q   <= 1'b0;
      node_count_q  <= '0;
      lls_q         <= '0;
      layer_count_q <= '0;
      step_layer_q  <= '0;
      from_mem_q    <= 1'b0;
      scan_idx_q    <= '0;
      ign_q         <= 1'b1;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      out_valid_q  <= out_valid_d;
      step_layer_q <= step_layer_d;
      from_mem_q   <= from_mem_d;
      scan_idx_q   <= scan_idx_d;
      ign_q        <= ign_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_NODE_COUNT:  node_count_q  <= cfg_data_i;
          CFG_LAST_LAYER:  lls_q         <= cfg_data_i[NODE_W-1:0];
          CFG_LAYER_COUNT: layer_count_q <= cfg_data_i[LAYER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    dst_q       <= dst_d;
    weight_q    <= weight_d;
    scan_addr_q <= scan_addr_d;
    goal_q      <= goal_d;
    best_cost_q <= best_cost_d;
    best_word_q <= best_word_d;
    if (out_load) out_q <= out_d;
  end

  // node store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_a_q <= mem_q[raddr_a];
      rd_b_q <= mem_q[raddr_b];
    end
  end

  `LDSP_ASSERT_IMP(a_relax_improves, (state_q == ST_RELAX) && mem_we, wdata.cost < rd_b_q.cost, "relax write without improvement")
  `LDSP_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_q || out_ready_i, "result overwritten before taken")
  `LDSP_ASSERT_IMP(a_no_graph_last, out_valid_o && (out_data_o.status == STATUS_NO_GRAPH), out_data_o.last, "no-graph result not last")
  `LDSP_ASSERT_NEXT(a_unreached_final, (state_q == ST_GOAL) && slot_free && (best_cost_q == COST_UNREACHED), out_valid_o && out_data_o.last, "unreached goal not final")

endmodule

// ===== rtl/ldsp_relax_unit.sv =====
// Edge relaxation: saturating cost sum and strict improvement test.
`timescale 1ns / 1ps
module ldsp_relax_unit #(
  parameter int unsigned WEIGHT_BITS = 24
) (
  input  logic [ldsp_pkg::COST_W-1:0]   cost_src_i,
  input  logic [ldsp_pkg::COST_W-1:0]   cost_dst_i,
  input  logic [ldsp_pkg::WEIGHT_W-1:0] weight_i,
  input  logic                          ignore_i,
  output ldsp_pkg::ldsp_relax_t         relax_o
);
  import ldsp_pkg::*;

  localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}} :
                                          WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  logic [WEIGHT_W-1:0] weight_m;
  logic [COST_W:0]     sum;
  logic [COST_W-1:0]   sat;

  always_comb begin
    weight_m = weight_i & WMASK;
    sum      = {1'b0, cost_src_i} + (COST_W+1)'(weight_m);
    sat      = sum[COST_W] ? COST_UNREACHED : sum[COST_W-1:0];
    relax_o.cost    = sat;
    relax_o.improve = !ignore_i && (sat != COST_UNREACHED) && (sat < cost_dst_i);
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the layered DAG shortest path block.
`timescale 1ns / 1ps
module tb_top;
  import ldsp_pkg::*;

  localparam int unsigned TB_MAX_NODES   = 1024;
  localparam int unsigned TB_MAX_LAYERS  = 63;
  localparam int unsigned NODE_MAX       = 1023;
  localparam int unsigned CFG_NODES_TOP  = 2047;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
  localparam int unsigned RELAX_SETTLE   = 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_TAIL     = 1100;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam int unsigned RANDOM_REQS    = 400;

  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] nodes;
    logic [CNT_W-1:0] lls;
    logic [CNT_W-1:0] layers;
    ldsp_in_t         req;
    logic             typed;
    ldsp_out_t        res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  ldsp_in_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  ldsp_out_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CNT_W-1:0]     cfg_data_i = '0;

  layered_dag_shortest_path_top #(
    .MAX_NODES  (TB_MAX_NODES),
    .MAX_LAYERS (TB_MAX_LAYERS),
    .WEIGHT_BITS(WEIGHT_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the node store and registers
  logic [COST_W-1:0] cost_mem [TB_MAX_NODES];
  logic [NODE_W-1:0] parent_mem [TB_MAX_NODES];
  logic              parent_ok [TB_MAX_NODES];
  logic [CNT_W-1:0]   reg_nodes = '0;
  logic [NODE_W-1:0]  reg_lls = '0;
  logic [LAYER_W-1:0] reg_layers = '0;

  ldsp_out_t   step_out[$];
  ldsp_out_t   path_q[$];
  dir_row_t    dir_tab[$];

  int unsigned errors = 0;
  int unsigned reqs_sent = 0;
  int unsigned solves_sent = 0;
  int unsigned nodes_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned in_stall = 0;
  int unsigned max_path = 0;
  int unsigned send_burst = 0;
  bit          hold_req = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic ldsp_out_t path_node(input int unsigned layer, input int unsigned node,
                                          input logic [COST_W-1:0] cost,
                                          input logic [STAT_W-1:0] status, input logic last);
    ldsp_out_t o;
    o.layer     = layer[LAYER_W-1:0];
    o.node      = node[NODE_W-1:0];
    o.goal_cost = cost;
    o.status    = status;
    o.last      = last;
    return o;
  endfunction

  function automatic ldsp_in_t relax_req(input int unsigned src, input int unsigned dst,
                                         input logic [WEIGHT_W-1:0] w);
    ldsp_in_t r;
    r.kind     = KIND_RELAX;
    r.src_node = src[NODE_W-1:0];
    r.dst_node = dst[NODE_W-1:0];
    r.weight   = w;
    return r;
  endfunction

  function automatic ldsp_in_t solve_req();
    ldsp_in_t r;
    r.kind     = KIND_SOLVE;
    r.src_node = NODE_W'($urandom);
    r.dst_node = NODE_W'($urandom);
    r.weight   = WEIGHT_W'($urandom);
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input int unsigned nodes, input int unsigned lls,
                                       input int unsigned layers);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.nodes  = nodes[CNT_W-1:0];
    r.lls    = lls[CNT_W-1:0];
    r.layers = layers[CNT_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t row_req(input ldsp_in_t req);
    dir_row_t r;
    r     = '0;
    r.req = req;
    return r;
  endfunction

  function automatic dir_row_t row_solve_is(input ldsp_out_t res);
    dir_row_t r;
    r       = '0;
    r.req   = solve_req();
    r.typed = 1'b1;
    r.res   = res;
    return r;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WEIGHT_MAX;
      2, 3: return WEIGHT_W'($urandom);
      default: return WEIGHT_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic ldsp_in_t noise_req(input int unsigned used);
    case ($urandom_range(0, 2))
      0: return relax_req($urandom, $urandom, pick_weight());
      1: return relax_req($urandom_range(0, used - 1), $urandom_range(0, used - 1),
                          pick_weight());
      default: return relax_req($urandom, $urandom_range(0, used - 1), pick_weight());
    endcase
  endfunction

  function automatic int unsigned node_at(input int unsigned k, input int unsigned a,
                                          input int unsigned wd);
    return (k == 0) ? 0 : 1 + (k - 1) * wd + a;
  endfunction

  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 5) == 0) begin
      burst = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void clear_nodes();
    for (int i = 0; i < TB_MAX_NODES; i++) begin
      cost_mem[i]   = COST_UNREACHED;
      parent_mem[i] = '0;
      parent_ok[i]  = 1'b0;
    end
    cost_mem[0] = '0;
  endfunction

  // relax one edge or run a solve against the shadow store; results land in step_out
  task automatic shortest_path_step(input ldsp_in_t r);
    int unsigned n, lay, goal, child, i;
    logic [COST_W:0] sum;
    logic [COST_W-1:0] cand, best;
    int t;
    step_out.delete();
    n   = (reg_nodes > TB_MAX_NODES) ? TB_MAX_NODES : reg_nodes;
    lay = (reg_layers > TB_MAX_LAYERS) ? TB_MAX_LAYERS : reg_layers;
    if (r.kind == KIND_RELAX) begin
      if (n != 0 && r.src_node < n && r.dst_node < n) begin
        sum  = {1'b0, cost_mem[r.src_node]} + {{(COST_W + 1 - WEIGHT_W){1'b0}}, r.weight};
        cand = sum[COST_W] ? COST_UNREACHED : sum[COST_W-1:0];
        if (cand != COST_UNREACHED && cand < cost_mem[r.dst_node]) begin
          cost_mem[r.dst_node]   = cand;
          parent_mem[r.dst_node] = r.src_node;
          parent_ok[r.dst_node]  = 1'b1;
        end
      end
    end else begin
      if (n == 0) begin
        step_out = {step_out, path_node(0, 0, '0, STATUS_NO_GRAPH, 1'b1)};
      end else if (reg_lls >= n) begin
        step_out = {step_out, path_node(lay, 0, COST_UNREACHED, STATUS_UNREACH, 1'b1)};
      end else begin
        goal = 32'(reg_lls);
        best = cost_mem[goal];
        for (i = reg_lls + 1; i < n; i++) begin
          if (cost_mem[i] < best) begin
            best = cost_mem[i];
            goal = i;
          end
        end
        if (best == COST_UNREACHED) begin
          step_out = {step_out, path_node(lay, goal, COST_UNREACHED, STATUS_UNREACH, 1'b1)};
        end else begin
          step_out = {step_out, path_node(lay, goal, best, STATUS_OK, lay == 0)};
          child = goal;
          for (t = int'(lay) - 1; t >= 0; t--) begin
            if (!parent_ok[child]) begin
              step_out = {step_out, path_node(t, 0, best, STATUS_UNREACH, 1'b1)};
              break;
            end
            child = 32'(parent_mem[child]);
            step_out = {step_out, path_node(t, child, best, STATUS_OK, t == 0)};
          end
        end
      end
      clear_nodes();
    end
  endtask

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_node(input ldsp_out_t got);
    ldsp_out_t want;
    nodes_checked++;
    if (path_q.size() == 0) begin
      report($sformatf("unexpected path node layer %0d node %0d status %0d",
                       got.layer, got.node, got.status));
      return;
    end
    want = path_q.pop_front();
    if (got.layer !== want.layer)
      report($sformatf("layer got %0d want %0d", got.layer, want.layer));
    if (got.node !== want.node)
      report($sformatf("node got %0d want %0d (layer %0d)", got.node, want.node, want.layer));
    if (got.goal_cost !== want.goal_cost)
      report($sformatf("goal_cost got %0h want %0h (layer %0d)",
                       got.goal_cost, want.goal_cost, want.layer));
    if (got.status !== want.status)
      report($sformatf("status got %0d want %0d (layer %0d)", got.status, want.status,
                       want.layer));
    if (got.last !== want.last)
      report($sformatf("last got %0d want %0d (layer %0d)", got.last, want.last, want.layer));
  endtask

  task automatic send_req(input ldsp_in_t r, input logic typed, input ldsp_out_t typed_res);
    int unsigned gap;
    gap = draw_gap(send_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do begin
      @(posedge clk_i);
      if (!in_ready_o) in_stall++;
    end while (!in_ready_o);
    shortest_path_step(r);
    if (step_out.size() > max_path) max_path = step_out.size();
    if (typed) path_q = {path_q, typed_res};
    else path_q = {path_q, step_out};
    reqs_sent++;
    if (r.kind == KIND_SOLVE) solves_sent++;
  endtask

  // registers change only once every path node is out and the last edge has settled
  task automatic write_regs(input logic [CNT_W-1:0] nodes, input logic [CNT_W-1:0] lls,
                            input logic [CNT_W-1:0] layers);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CNT_W-1:0]     val [3];
    idx = '{CFG_NODE_COUNT, CFG_LAST_LAYER, CFG_LAYER_COUNT};
    val = '{nodes, lls, layers};
    in_valid_i <= 1'b0;
    while (path_q.size() != 0) @(posedge clk_i);
    repeat (RELAX_SETTLE) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        CFG_NODE_COUNT:  reg_nodes  = val[i];
        CFG_LAST_LAYER:  reg_lls    = val[i][NODE_W-1:0];
        CFG_LAYER_COUNT: reg_layers = val[i][LAYER_W-1:0];
        default: ;
      endcase
      cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // layered graph: node 0 alone in layer 0, then nl layers of wd nodes, edges layer by layer
  task automatic run_phase(input bit pressure);
    int unsigned nl, wd, used, lls, layers, nodes, k, a, b, sw;
    if (pressure) begin
      nl = TB_MAX_LAYERS;
    end else begin
      case ($urandom_range(0, 19))
        0: nl = 0;
        1: nl = $urandom_range(7, TB_MAX_LAYERS);
        default: nl = $urandom_range(1, 5);
      endcase
    end
    wd     = (nl >= 7) ? 1 : $urandom_range(1, 4);
    used   = (nl == 0) ? $urandom_range(1, 4) : 1 + nl * wd;
    lls    = (nl == 0) ? 0 : 1 + (nl - 1) * wd;
    nodes  = used;
    layers = nl;
    if (!pressure) begin
      case ($urandom_range(0, 9))
        0: nodes = 0;
        1: nodes = $urandom_range(0, 1) ? TB_MAX_NODES : CFG_NODES_TOP;
        2: lls = $urandom_range(0, NODE_MAX);
        3: layers = $urandom_range(0, TB_MAX_LAYERS);
        default: ;
      endcase
    end
    write_regs(CNT_W'(nodes), CNT_W'(lls), CNT_W'(layers));
    for (k = 0; k < nl; k++) begin
      sw = (k == 0) ? 1 : wd;
      for (a = 0; a < sw; a++) begin
        for (b = 0; b < wd; b++) begin
          if ($urandom_range(0, 9) == 0) send_req(noise_req(used), 1'b0, '0);
          if ((a == 0 && b == 0) || $urandom_range(0, 9) < 7)
            send_req(relax_req(node_at(k, a, wd), node_at(k + 1, b, wd), pick_weight()),
                     1'b0, '0);
        end
      end
    end
    if (nl == 0) repeat ($urandom_range(1, 3)) send_req(noise_req(used), 1'b0, '0);
    if (pressure) hold_req = 1'b1;
    send_req(solve_req(), 1'b0, '0);
    if (pressure || $urandom_range(0, 9) == 0) begin
      repeat (3) send_req(noise_req(used), 1'b0, '0);
      send_req(solve_req(), 1'b0, '0);
    end
  endtask

  initial begin : receiver
    int unsigned gap, burst;
    burst = 0;
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = draw_gap(burst);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
      check_node(out_data_o);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles, %0d path nodes outstanding",
             $time, quiet, path_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase, dir_reqs;
    clear_nodes();
    dir_tab = '{
      row_solve_is(path_node(0, 0, '0, STATUS_NO_GRAPH, 1'b1)),
      row_req(relax_req(0, 1, WEIGHT_W'(5))),
      row_cfg(TB_MAX_NODES, NODE_MAX, TB_MAX_LAYERS),
      row_solve_is(path_node(TB_MAX_LAYERS, NODE_MAX, COST_UNREACHED, STATUS_UNREACH, 1'b1)),
      row_req(relax_req(NODE_MAX, NODE_MAX, '0)),
      row_req(relax_req(0, NODE_MAX, WEIGHT_MAX)),
      row_req(solve_req()),
      row_cfg(8, 8, 2),
      row_solve_is(path_node(2, 0, COST_UNREACHED, STATUS_UNREACH, 1'b1)),
      row_cfg(8, 5, 2),
      row_req(relax_req(0, 1, '0)),
      row_req(relax_req(0, 2, WEIGHT_MAX)),
      row_req(relax_req(1, 3, WEIGHT_W'(10))),
      row_req(relax_req(2, 3, '0)),
      row_req(relax_req(9, 3, '0)),
      row_req(relax_req(3, NODE_MAX, WEIGHT_W'(1))),
      row_req(relax_req(4, 5, '0)),
      row_req(relax_req(6, 7, WEIGHT_MAX)),
      row_req(relax_req(3, 6, WEIGHT_W'(7))),
      row_req(relax_req(3, 5, WEIGHT_W'(7))),
      row_req(relax_req(3, 7, WEIGHT_W'(9))),
      row_req(solve_req()),
      row_cfg(8, 2, 5),
      row_req(relax_req(0, 2, WEIGHT_W'(3))),
      row_req(solve_req()),
      row_cfg(1, 0, 0),
      row_solve_is(path_node(0, 0, '0, STATUS_OK, 1'b1))
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_regs(dir_tab[i].nodes, dir_tab[i].lls, dir_tab[i].layers);
      else send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    end

    dir_reqs = reqs_sent;
    phase    = 0;
    while (reqs_sent < dir_reqs + RANDOM_REQS) begin
      run_phase(phase == 2);
      phase++;
    end

    in_valid_i <= 1'b0;
    while (path_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("summary: %0d requests (%0d solves) over %0d graphs, %0d path nodes checked",
             reqs_sent, solves_sent, phase, nodes_checked);
    $display("summary: %0d register writes, longest path %0d nodes, input held %0d cycles",
             cfg_writes, max_path, in_stall);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
